// ===== rtl/rddm_pkg.sv =====
// ----------------------------------------------------------------------------
// rddm_pkg
// Shared constants, codes and the curve factor table of the ramped
// differential drive mixer.
// ----------------------------------------------------------------------------
package rddm_pkg;

    // Fixed point format of all commands and motor values.
    localparam int FRAC_BITS        = 14;
    localparam int VAL_W            = 16;
    localparam int CFG_W            = 15;

    // Curve table geometry: the table spans |turn| in [0, 32768).
    localparam int CURVE_TABLE_BITS = 8;
    localparam int CURVE_ENTRIES    = 1 << CURVE_TABLE_BITS;
    localparam int CURVE_SHIFT      = 15 - CURVE_TABLE_BITS;

    // A factor of magnitude ONE * 2^FRAC_BITS already drives any nonzero
    // speed to the clamp, so larger factors are saturated there.
    localparam int FACTOR_W         = 2 * FRAC_BITS + 2;
    localparam logic signed [63:0] FACTOR_SAT = 64'sd1 <<< (2 * FRAC_BITS);

    localparam logic signed [63:0] LN2_Q20 = 64'sd726817;

    localparam logic signed [VAL_W-1:0] ONE_Q = VAL_W'(64'sd1 <<< FRAC_BITS);

    // Register reset values.
    localparam logic [CFG_W-1:0] RST_RAMP_STEP_FAST  = 15'd1638;
    localparam logic [CFG_W-1:0] RST_RAMP_STEP_SLOW  = 15'd819;
    localparam logic [CFG_W-1:0] RST_RAMP_SMALL_BAND = 15'd1638;
    localparam logic [CFG_W-1:0] RST_DEAD_TURN_BAND  = 15'd1638;

    // Register indexes.
    typedef logic [1:0] t_cfg_index;
    localparam t_cfg_index CFG_RAMP_STEP_FAST  = 2'd0;
    localparam t_cfg_index CFG_RAMP_STEP_SLOW  = 2'd1;
    localparam t_cfg_index CFG_RAMP_SMALL_BAND = 2'd2;
    localparam t_cfg_index CFG_DEAD_TURN_BAND  = 2'd3;

    // Command codes.
    typedef enum logic [1:0] {
        ACT_RAMPED   = 2'd0,
        ACT_UNRAMPED = 2'd1,
        ACT_MECANUM  = 2'd2,
        ACT_TANK     = 2'd3
    } t_action;

    typedef logic signed [FACTOR_W-1:0] t_curve_rom [CURVE_ENTRIES];

    // Restoring long division, used only while the table is elaborated.
    function automatic logic [63:0] f_udiv(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] q;
        logic [63:0] rem;
        int          i;
        q   = '0;
        rem = '0;
        for (i = 63; i >= 0; i--) begin
            rem = {rem[62:0], num[i]};
            if (rem >= den) begin
                rem  = rem - den;
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // Quotient rounded half away from zero.
    function automatic logic signed [63:0] f_rdiv(input logic signed [63:0] num,
                                                  input logic signed [63:0] den);
        logic        neg;
        logic [63:0] un;
        logic [63:0] ud;
        logic [63:0] q;
        neg = 1'b0;
        if (den == 0) begin
            return '0;
        end
        if (num < 0) begin
            neg = !neg;
            un  = 64'(-num);
        end else begin
            un  = 64'(num);
        end
        if (den < 0) begin
            neg = !neg;
            ud  = 64'(-den);
        end else begin
            ud  = 64'(den);
        end
        q = f_udiv(un + (ud >> 1), ud);
        return neg ? -$signed(q) : $signed(q);
    endfunction

    // Natural log of c / 2^FRAC_BITS with 20 fraction bits.
    function automatic logic signed [63:0] f_ln_q20(input logic [31:0] c);
        int                 n;
        int                 i;
        logic [63:0]        y;
        logic signed [63:0] frac;
        logic signed [63:0] acc;
        n    = 0;
        frac = '0;
        for (i = 0; i < 31; i++) begin
            if ((c >> (i + 1)) != 0) begin
                n = i + 1;
            end
        end
        y = {32'd0, c} << (30 - n);
        for (i = 19; i >= 0; i--) begin
            y = (y * y) >> 30;
            if (y >= (64'd1 << 31)) begin
                y    = y >> 1;
                frac = frac | (64'sd1 <<< i);
            end
        end
        acc = ((longint'(n - FRAC_BITS) <<< 20) + frac) * LN2_Q20;
        return f_rdiv(acc, 64'sd1 <<< 20);
    endfunction

    // Inner wheel factor (ln t + 0.5) / (ln t - 0.5) at each bin center.
    function automatic t_curve_rom f_build_curve_rom();
        t_curve_rom         rom;
        int                 k;
        logic [31:0]        c;
        logic signed [63:0] m;
        logic signed [63:0] num;
        logic signed [63:0] den;
        logic signed [63:0] f;
        for (k = 0; k < CURVE_ENTRIES; k++) begin
            c   = 32'((k << CURVE_SHIFT) + (1 << (CURVE_SHIFT - 1)));
            m   = f_ln_q20(c);
            num = m + (64'sd1 <<< 19);
            den = m - (64'sd1 <<< 19);
            if (den == 0) begin
                f = (num > 0) ? FACTOR_SAT : ((num < 0) ? -FACTOR_SAT : 64'sd0);
            end else begin
                f = f_rdiv(num <<< FRAC_BITS, den);
            end
            if (f > FACTOR_SAT) begin
                f = FACTOR_SAT;
            end else if (f < -FACTOR_SAT) begin
                f = -FACTOR_SAT;
            end
            rom[k] = FACTOR_W'(f);
        end
        return rom;
    endfunction

    localparam t_curve_rom CURVE_ROM = f_build_curve_rom();

endpackage

// ===== rtl/ramped_differential_drive_mixer.sv =====
// ----------------------------------------------------------------------------
// ramped_differential_drive_mixer
// Turns one drive command into four motor values: ramped or direct curvature
// drive, ramped mecanum routing, or tank pass-through.
// ----------------------------------------------------------------------------
// Usage:
// An item enters on i_in_valid / o_in_stall and carries the action code and
// two signed Q1.14 commands. Each item yields exactly one result item of four
// signed Q1.14 motor values on o_out_valid / i_out_stall.
// The datapath is three register stages deep: an input register, a stage that
// ramps the stored speed, turn, x and y values and looks up the curve factor,
// and a result register behind the single speed-times-factor multiplier.
// An item passes the mix stage, then the result register. While the receiver
// does not stall, one item can be accepted on every cycle, so the sustained rate is one item per cycle.
// When the receiver stalls, the result register holds its item and the
// earlier stages keep filling; o_in_stall rises only once all three stages
// are occupied, and it follows i_out_stall within the same cycle.
// Reset (synchronous, active low) empties the pipeline, zeroes the ramp
// history and loads the register defaults; o_in_stall is high during reset.
// The four registers are written through i_cfg_we / i_cfg_index / i_cfg_data
// and should be changed only while no item is in flight.
// ----------------------------------------------------------------------------
module ramped_differential_drive_mixer (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Command channel
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [1:0]                          i_action,
    input  logic signed [rddm_pkg::VAL_W-1:0]   i_command_a,
    input  logic signed [rddm_pkg::VAL_W-1:0]   i_command_b,
    // Motor value channel
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [rddm_pkg::VAL_W-1:0]   o_front_left,
    output logic signed [rddm_pkg::VAL_W-1:0]   o_front_right,
    output logic signed [rddm_pkg::VAL_W-1:0]   o_back_left,
    output logic signed [rddm_pkg::VAL_W-1:0]   o_back_right,
    // Register write port
    input  logic                                i_cfg_we,
    input  rddm_pkg::t_cfg_index                i_cfg_index,
    input  logic [rddm_pkg::CFG_W-1:0]          i_cfg_data
);

    localparam int VW = rddm_pkg::VAL_W;
    localparam int FW = rddm_pkg::FACTOR_W;
    localparam int PW = VW + FW;
    localparam int TB = rddm_pkg::CURVE_TABLE_BITS;
    localparam int FB = rddm_pkg::FRAC_BITS;

    // Magnitude of a signed value; the most negative value maps to 2^(VW-1).
    function automatic logic [VW-1:0] f_mag(input logic signed [VW-1:0] v);
        return v[VW-1] ? (~v + 1'b1) : v;
    endfunction

    // Move cur one full step toward want, saturating to the value range.
    function automatic logic signed [VW-1:0] f_ramp(
        input logic signed [VW-1:0]           want,
        input logic signed [VW-1:0]           cur,
        input logic [rddm_pkg::CFG_W-1:0]     step_fast,
        input logic [rddm_pkg::CFG_W-1:0]     step_slow,
        input logic [rddm_pkg::CFG_W-1:0]     band
    );
        logic [rddm_pkg::CFG_W-1:0] inc;
        logic signed [VW+1:0]       sum;
        inc = (f_mag(want) <= {1'b0, band}) ? step_slow : step_fast;
        if (want < cur) begin
            sum = (VW+2)'(cur) - $signed({3'b000, inc});
        end else if (want > cur) begin
            sum = (VW+2)'(cur) + $signed({3'b000, inc});
        end else begin
            sum = (VW+2)'(cur);
        end
        if (sum > (VW+2)'(32767)) begin
            return 16'sh7FFF;
        end else if (sum < -(VW+2)'(32768)) begin
            return 16'sh8000;
        end else begin
            return VW'(sum);
        end
    endfunction

    // Clamp a wide signed value to [-1.0, +1.0].
    function automatic logic signed [VW-1:0] f_clamp_one(input logic signed [PW-1:0] v);
        if (v > PW'(rddm_pkg::ONE_Q)) begin
            return rddm_pkg::ONE_Q;
        end else if (v < -PW'(rddm_pkg::ONE_Q)) begin
            return -rddm_pkg::ONE_Q;
        end else begin
            return VW'(v);
        end
    endfunction

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    logic [rddm_pkg::CFG_W-1:0] r_ramp_step_fast;
    logic [rddm_pkg::CFG_W-1:0] r_ramp_step_slow;
    logic [rddm_pkg::CFG_W-1:0] r_ramp_small_band;
    logic [rddm_pkg::CFG_W-1:0] r_dead_turn_band;

    logic signed [VW-1:0] r_speed_last;
    logic signed [VW-1:0] r_turn_last;
    logic signed [VW-1:0] r_x_last;
    logic signed [VW-1:0] r_y_last;

    // Input register stage.
    logic                 r_a_valid;
    rddm_pkg::t_action    r_a_action;
    logic signed [VW-1:0] r_a_cmd_a;
    logic signed [VW-1:0] r_a_cmd_b;

    // Mix stage: either four finished values, or speed and factor that
    // still go through the multiplier.
    logic                 r_b_valid;
    logic                 r_b_curve;
    logic                 r_b_inner_left;
    logic signed [VW-1:0] r_b_speed;
    logic signed [FW-1:0] r_b_factor;
    logic signed [VW-1:0] r_b_fl;
    logic signed [VW-1:0] r_b_fr;
    logic signed [VW-1:0] r_b_bl;
    logic signed [VW-1:0] r_b_br;

    // Result register.
    logic                 r_out_valid;
    logic signed [VW-1:0] r_out_fl;
    logic signed [VW-1:0] r_out_fr;
    logic signed [VW-1:0] r_out_bl;
    logic signed [VW-1:0] r_out_br;

    // ------------------------------------------------------------------
    // Flow control: each stage advances when the stage after it is empty
    // or is itself moving on in this cycle.
    // ------------------------------------------------------------------
    logic out_free;
    logic adv_out;
    logic b_free;
    logic adv_b;
    logic a_free;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign adv_out    = r_b_valid && out_free;
    assign b_free     = !r_b_valid || adv_out;
    assign adv_b      = r_a_valid && b_free;
    assign a_free     = !r_a_valid || adv_b;
    assign o_in_stall = !a_free || !i_rst_n;

    // ------------------------------------------------------------------
    // Mix stage logic
    // ------------------------------------------------------------------
    logic signed [VW-1:0] ramp_speed;
    logic signed [VW-1:0] ramp_turn;
    logic signed [VW-1:0] ramp_x;
    logic signed [VW-1:0] ramp_y;

    assign ramp_speed = f_ramp(r_a_cmd_a, r_speed_last, r_ramp_step_fast,
                               r_ramp_step_slow, r_ramp_small_band);
    assign ramp_turn  = f_ramp(r_a_cmd_b, r_turn_last, r_ramp_step_fast,
                               r_ramp_step_slow, r_ramp_small_band);
    assign ramp_x     = f_ramp(r_a_cmd_a, r_x_last, r_ramp_step_fast,
                               r_ramp_step_slow, r_ramp_small_band);
    assign ramp_y     = f_ramp(r_a_cmd_b, r_y_last, r_ramp_step_fast,
                               r_ramp_step_slow, r_ramp_small_band);

    logic signed [VW-1:0]    mix_speed;
    logic signed [VW-1:0]    mix_turn;
    logic [VW-1:0]           turn_mag;
    logic [VW+1:0]           dead_mag;
    logic signed [VW-1:0]    dead_left;
    logic                    dead_turn;
    logic [14:0]             turn_cap;
    logic [TB-1:0]           curve_idx;
    logic signed [FW-1:0]    curve_factor;

    assign mix_speed = (r_a_action == rddm_pkg::ACT_RAMPED) ? ramp_speed : r_a_cmd_a;
    assign mix_turn  = (r_a_action == rddm_pkg::ACT_RAMPED) ? ramp_turn  : r_a_cmd_b;
    assign turn_mag  = f_mag(mix_turn);

    // A small but nonzero speed spins in place at three quarters of the turn.
    assign dead_turn = (mix_speed != '0) && (f_mag(mix_speed) <= {1'b0, r_dead_turn_band});
    assign dead_mag  = (((VW+2)'(turn_mag) * (VW+2)'(3)) + (VW+2)'(2)) >> 2;
    assign dead_left = mix_turn[VW-1] ? -VW'(dead_mag) : VW'(dead_mag);

    assign turn_cap     = (turn_mag > 16'd32767) ? 15'h7FFF : turn_mag[14:0];
    assign curve_idx    = turn_cap[14:rddm_pkg::CURVE_SHIFT];
    assign curve_factor = (mix_turn == '0) ? FW'(rddm_pkg::ONE_Q)
                                           : rddm_pkg::CURVE_ROM[curve_idx];

    logic                 n_b_curve;
    logic signed [VW-1:0] n_b_fl;
    logic signed [VW-1:0] n_b_fr;
    logic signed [VW-1:0] n_b_bl;
    logic signed [VW-1:0] n_b_br;

    always_comb begin
        n_b_curve = 1'b0;
        n_b_fl    = r_a_cmd_a;
        n_b_fr    = r_a_cmd_b;
        n_b_bl    = r_a_cmd_a;
        n_b_br    = r_a_cmd_b;
        case (r_a_action)
            rddm_pkg::ACT_RAMPED, rddm_pkg::ACT_UNRAMPED: begin
                n_b_curve = !dead_turn;
                n_b_fl    = dead_left;
                n_b_bl    = dead_left;
                n_b_fr    = -dead_left;
                n_b_br    = -dead_left;
            end
            rddm_pkg::ACT_MECANUM: begin
                n_b_fl = ramp_x;
                n_b_br = ramp_x;
                n_b_fr = ramp_y;
                n_b_bl = ramp_y;
            end
            rddm_pkg::ACT_TANK: begin
                n_b_fl = r_a_cmd_a;
                n_b_bl = r_a_cmd_a;
                n_b_fr = r_a_cmd_b;
                n_b_br = r_a_cmd_b;
            end
            default: begin
                n_b_curve = 1'b0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Result stage logic: inner wheel = speed * factor, rounded half away
    // from zero, then both wheels clamped to +-1.0.
    // ------------------------------------------------------------------
    logic signed [PW-1:0] prod;
    logic [PW-1:0]        prod_mag;
    logic [PW-1:0]        inner_mag;
    logic signed [PW-1:0] inner;
    logic signed [VW-1:0] curve_left;
    logic signed [VW-1:0] curve_right;

    assign prod      = PW'(r_b_speed) * PW'(r_b_factor);
    assign prod_mag  = prod[PW-1] ? PW'(-prod) : PW'(prod);
    assign inner_mag = (prod_mag + (PW'(1) << (FB - 1))) >> FB;
    assign inner     = prod[PW-1] ? -$signed(inner_mag) : $signed(inner_mag);

    assign curve_left  = f_clamp_one(r_b_inner_left ? inner : PW'(r_b_speed));
    assign curve_right = f_clamp_one(r_b_inner_left ? PW'(r_b_speed) : inner);

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid         <= 1'b0;
            r_b_valid         <= 1'b0;
            r_out_valid       <= 1'b0;
            r_speed_last      <= '0;
            r_turn_last       <= '0;
            r_x_last          <= '0;
            r_y_last          <= '0;
            r_ramp_step_fast  <= rddm_pkg::RST_RAMP_STEP_FAST;
            r_ramp_step_slow  <= rddm_pkg::RST_RAMP_STEP_SLOW;
            r_ramp_small_band <= rddm_pkg::RST_RAMP_SMALL_BAND;
            r_dead_turn_band  <= rddm_pkg::RST_DEAD_TURN_BAND;
        end else begin
            if (a_free) begin
                r_a_valid <= i_in_valid;
            end
            if (b_free) begin
                r_b_valid <= r_a_valid;
            end
            if (out_free) begin
                r_out_valid <= r_b_valid;
            end
            if (adv_b) begin
                case (r_a_action)
                    rddm_pkg::ACT_RAMPED: begin
                        r_speed_last <= ramp_speed;
                        r_turn_last  <= ramp_turn;
                    end
                    rddm_pkg::ACT_MECANUM: begin
                        r_x_last <= ramp_x;
                        r_y_last <= ramp_y;
                    end
                    default: begin
                    end
                endcase
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    rddm_pkg::CFG_RAMP_STEP_FAST:  r_ramp_step_fast  <= i_cfg_data;
                    rddm_pkg::CFG_RAMP_STEP_SLOW:  r_ramp_step_slow  <= i_cfg_data;
                    rddm_pkg::CFG_RAMP_SMALL_BAND: r_ramp_small_band <= i_cfg_data;
                    rddm_pkg::CFG_DEAD_TURN_BAND:  r_dead_turn_band  <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (a_free) begin
            r_a_action <= rddm_pkg::t_action'(i_action);
            r_a_cmd_a  <= i_command_a;
            r_a_cmd_b  <= i_command_b;
        end
        if (adv_b) begin
            r_b_curve      <= n_b_curve;
            r_b_inner_left <= mix_turn[VW-1];
            r_b_speed      <= mix_speed;
            r_b_factor     <= curve_factor;
            r_b_fl         <= n_b_fl;
            r_b_fr         <= n_b_fr;
            r_b_bl         <= n_b_bl;
            r_b_br         <= n_b_br;
        end
        if (adv_out) begin
            r_out_fl <= r_b_curve ? curve_left  : r_b_fl;
            r_out_fr <= r_b_curve ? curve_right : r_b_fr;
            r_out_bl <= r_b_curve ? curve_left  : r_b_bl;
            r_out_br <= r_b_curve ? curve_right : r_b_br;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_front_left  = r_out_fl;
    assign o_front_right = r_out_fr;
    assign o_back_left   = r_out_bl;
    assign o_back_right  = r_out_br;

`ifndef NO_ASSERTIONS
    // An item that moves out of the input stage lands in the mix stage.
    a_mix_stage_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv_b |=> r_b_valid)
        else $error("mix stage lost an item");

    // The curvature ramp history changes only when a ramped item passes.
    a_drive_history_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(adv_b && (r_a_action == rddm_pkg::ACT_RAMPED))
            |=> ($stable(r_speed_last) && $stable(r_turn_last)))
        else $error("drive ramp history changed without a ramped item");

    // A curvature mix result never leaves the +-1.0 range.
    a_curve_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv_out && r_b_curve) |=>
            (o_front_left <= rddm_pkg::ONE_Q) && (o_front_left >= -rddm_pkg::ONE_Q) &&
            (o_front_right <= rddm_pkg::ONE_Q) && (o_front_right >= -rddm_pkg::ONE_Q))
        else $error("curvature result outside the clamp range");

    // A result held under stall keeps the upstream stage from being dropped.
    a_held_result_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall && r_b_valid) |=> r_b_valid)
        else $error("mix stage emptied while the result was stalled");
`endif

endmodule
